// ----- src/rsas_pkg.sv -----
`default_nettype none
package rsas_pkg;

   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int DATA_W = 32;
   localparam int LEN_W  = 11;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_L,
      S_RD_M,
      S_RD_R,
      S_CMP
   } state_type;

endpackage
`default_nettype wire

// ----- src/rsas_ram.sv -----
`default_nettype none
module rsas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ----- src/rotated_sorted_array_search_top.sv -----
`default_nettype none
// Search: an empty sequence gets its result beat at the accepting edge; else left is
// read once, then each step reads mid and right-1 from the one read port and compares;
// at most 11 steps at full depth. A write is stored at the accepting edge, no beat.
// One item at a time: busy is high while a search runs. The result is shown for one
// cycle; the receiver cannot stall it. Synchronous reset clears control and the length
// register; the store is not cleared.
module rotated_sorted_array_search_top
   import rsas_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     req_op,
   input  wire logic [ADDR_W-1:0]        req_index,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [ADDR_W-1:0]             rsp_position,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [LEN_W-1:0]         csr_data
);

   state_type state_ff, state_in;

   logic [LEN_W-1:0]         length_ff;
   logic [CNT_W-1:0]         left_ff, left_in, right_ff, right_in;
   logic signed [DATA_W-1:0] key_ff, key_in, lv_ff, lv_in, mv_ff, mv_in;
   logic                     first_ff, first_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [ADDR_W-1:0]        rsp_position_ff, rsp_position_in;

   logic                     accept;
   logic [CNT_W-1:0]         count;
   logic [CNT_W:0]           sum;
   logic [CNT_W-1:0]         mid, right_m1;
   logic [ADDR_W-1:0]        rd_addr;
   logic [DATA_W-1:0]        rd_data;
   logic signed [DATA_W-1:0] rv;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign count     = (length_ff > LEN_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(length_ff);
   assign sum       = {1'b0, left_ff} + {1'b0, right_ff};
   assign mid       = sum[CNT_W:1];
   assign right_m1  = right_ff - CNT_W'(1);
   assign rv        = $signed(rd_data);

   rsas_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (accept && (req_op == OP_WRITE)),
      .wr_addr(req_index),
      .wr_data(req_value),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      unique case (state_ff)
         S_RD_M:  rd_addr = mid[ADDR_W-1:0];
         S_RD_R:  rd_addr = right_m1[ADDR_W-1:0];
         default: rd_addr = left_ff[ADDR_W-1:0];
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      left_in         = left_ff;
      right_in        = right_ff;
      key_in          = key_ff;
      lv_in           = lv_ff;
      mv_in           = mv_ff;
      first_in        = first_ff;
      rsp_valid_in    = 1'b0;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_op == OP_SEARCH)) begin
               key_in   = req_value;
               left_in  = '0;
               right_in = count;
               first_in = 1'b1;
               if (count == '0) begin
                  rsp_valid_in    = 1'b1;
                  rsp_found_in    = 1'b0;
                  rsp_position_in = '0;
               end else begin
                  state_in = S_RD_L;
               end
            end
         end
         S_RD_L: state_in = S_RD_M;
         S_RD_M: begin
            // left word only arrives here on the first step
            if (first_ff) begin
               lv_in = $signed(rd_data);
            end
            first_in = 1'b0;
            state_in = S_RD_R;
         end
         S_RD_R: begin
            mv_in    = $signed(rd_data);
            state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_RD_M;
            priority if (key_ff == mv_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_position_in = mid[ADDR_W-1:0];
               state_in        = S_IDLE;
            end else if (key_ff == lv_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_position_in = left_ff[ADDR_W-1:0];
               state_in        = S_IDLE;
            end else if (key_ff == rv) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_position_in = right_m1[ADDR_W-1:0];
               state_in        = S_IDLE;
            end else if ((right_ff == mid + CNT_W'(1)) || (left_ff == mid)) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b0;
               rsp_position_in = '0;
               state_in        = S_IDLE;
            end else if (key_ff >= lv_ff && key_ff <= mv_ff && key_ff <= rv) begin
               right_in = mid;
            end else if (key_ff >= lv_ff && key_ff >= mv_ff && key_ff <= rv && mv_ff <= rv) begin
               left_in = mid;
               lv_in   = mv_ff;
            end else if (key_ff >= lv_ff && key_ff >= mv_ff && mv_ff <= rv) begin
               right_in = mid;
            end else if (key_ff >= lv_ff && key_ff >= mv_ff) begin
               left_in = mid;
               lv_in   = mv_ff;
            end else if (key_ff <= rv && mv_ff >= rv) begin
               left_in = mid;
               lv_in   = mv_ff;
            end else if (lv_ff >= key_ff && key_ff <= mv_ff) begin
               right_in = mid;
            end else if (key_ff >= lv_ff && key_ff <= mv_ff) begin
               right_in = mid;
            end else if (key_ff >= mv_ff && key_ff <= rv) begin
               left_in = mid;
               lv_in   = mv_ff;
            end else if (key_ff <= rv) begin
               left_in = mid;
               lv_in   = mv_ff;
            end else begin
               right_in = mid + CNT_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         if (csr_valid && csr_ready) begin
            length_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      left_ff         <= left_in;
      right_ff        <= right_in;
      key_ff          <= key_in;
      lv_ff           <= lv_in;
      mv_ff           <= mv_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   // a result beat only follows a compare or an empty-sequence search
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == S_CMP || $past(state_ff) == S_IDLE))
      else $error("result beat from unexpected state");

   // write beats never produce a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_WRITE) |=> !rsp_valid_ff)
      else $error("result beat after a write");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_position_ff == '0))
      else $error("position not zero on a miss");

   // the search window stays non-empty and inside the store
   a_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (left_ff < right_ff && right_ff <= CNT_W'(DEPTH)))
      else $error("search window out of range");

endmodule
`default_nettype wire
